[rtl/bad_segment_remap_table_top_assert.svh]
// assertion helpers shared by the checker
`ifndef BAD_SEGMENT_REMAP_TABLE_TOP_ASSERT_SVH
`define BAD_SEGMENT_REMAP_TABLE_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define BSRT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define BSRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bsrt_pkg.sv]
package bsrt_pkg;

    localparam int SEG_COUNT_DEF = 512;

    localparam int ADDR_W     = 32;
    localparam int PAGE_BITS  = 14;
    localparam int BLK_W      = ADDR_W - PAGE_BITS;
    localparam int PAGE_LSB   = 6;
    localparam int PAGE_W     = 8;
    localparam int SEG_IDX_W  = 9;
    localparam int LSEG_W     = 10;
    localparam int COUNT_W    = 10;
    localparam int ACTION_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 10'd1023;
    localparam logic [LSEG_W-1:0]  LSEG_RESET  = 10'd256;
    localparam logic [ADDR_W-1:0]  PAGE_MASK   = 32'h0000_3FFF;

    // slc page fold thresholds
    localparam logic [PAGE_W-1:0] FOLD_PAGE_LO    = 8'd4;
    localparam logic [PAGE_W-1:0] FOLD_PAGE_HI    = 8'd254;
    localparam logic [PAGE_W-1:0] FOLD_PAGE_EDGE  = 8'd6;
    localparam logic [PAGE_W-1:0] FOLD_DROP_SHORT = 8'd4;
    localparam logic [PAGE_W-1:0] FOLD_DROP_LONG  = 8'd6;

    typedef enum logic [ACTION_W-1:0] {
        ACT_REPORT     = 3'd0,
        ACT_BUILD      = 3'd1,
        ACT_TRANSLATE  = 3'd2,
        ACT_SEG_QUERY  = 3'd3,
        ACT_PAIR_QUERY = 3'd4
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOGICAL_SEGMENTS  = 2'd0,
        CFG_SINGLE_LEVEL_SCAN = 2'd1,
        CFG_SLC_FOLD_ENABLE   = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        t_action               action;
        logic [SEG_IDX_W-1:0]  seg_index;
        logic                  is_bad;
        logic [ADDR_W-1:0]     work_addr;
        logic                  keep_offset;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] result;
        logic              status;
    } t_rsp;

endpackage

[rtl/bsrt_ram.sv]
module bsrt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/bsrt_addr.sv]
module bsrt_addr (
    input  bsrt_pkg::t_action                 i_action,
    input  logic [bsrt_pkg::ADDR_W-1:0]       i_page_address,
    input  logic [bsrt_pkg::LSEG_W-1:0]       i_logical_segments,
    input  logic                              i_slc_fold_enable,
    output logic [bsrt_pkg::ADDR_W-1:0]       o_work_addr,
    output logic                              o_keep_offset
);

    localparam int PB = bsrt_pkg::PAGE_BITS;
    localparam int AW = bsrt_pkg::ADDR_W;
    localparam int BW = bsrt_pkg::BLK_W;
    localparam int PL = bsrt_pkg::PAGE_LSB;
    localparam int PW = bsrt_pkg::PAGE_W;

    logic [PW-1:0] w_page;
    logic [PW-1:0] w_page_fold;
    logic          w_fold;
    logic [BW-1:0] w_block;
    logic [BW-1:0] w_lseg;
    logic [AW-1:0] w_trans;
    logic [AW-1:0] w_pair;

    assign w_page  = i_page_address[PL+PW-1:PL];
    assign w_block = i_page_address[AW-1:PB];
    assign w_lseg  = BW'(i_logical_segments);

    always_comb begin
        w_page_fold = w_page;
        w_fold      = 1'b0;
        if (w_page >= bsrt_pkg::FOLD_PAGE_LO) begin
            if (w_page >= bsrt_pkg::FOLD_PAGE_HI || w_page < bsrt_pkg::FOLD_PAGE_EDGE) begin
                w_page_fold = w_page - bsrt_pkg::FOLD_DROP_SHORT;
                w_fold      = 1'b1;
            end else if (w_page[1:0] < 2'd2) begin
                w_page_fold = (w_page > bsrt_pkg::FOLD_PAGE_EDGE) ?
                              w_page - bsrt_pkg::FOLD_DROP_LONG : w_page;
                w_fold      = 1'b1;
            end
        end
    end

    // folded pages move to the slc block range above the logical segments
    assign w_trans = i_slc_fold_enable ?
                     {w_block + (w_fold ? w_lseg : '0), w_page_fold, i_page_address[PL-1:0]} :
                     i_page_address;
    assign w_pair  = {w_block + w_lseg, {PB{1'b0}}};

    always_comb begin
        case (i_action)
            bsrt_pkg::ACT_TRANSLATE: begin
                o_work_addr   = w_trans;
                o_keep_offset = 1'b1;
            end
            bsrt_pkg::ACT_PAIR_QUERY: begin
                o_work_addr   = w_pair;
                o_keep_offset = 1'b0;
            end
            default: begin
                o_work_addr   = i_page_address;
                o_keep_offset = 1'b0;
            end
        endcase
    end

endmodule

[rtl/bsrt_seq.sv]
module bsrt_seq #(
    parameter int SEG_COUNT = bsrt_pkg::SEG_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  bsrt_pkg::t_req                i_req,
    input  logic [bsrt_pkg::LSEG_W-1:0]   i_logical_segments,
    input  logic                          i_single_level_scan,
    input  logic                          i_out_free,
    output logic                          o_idle,
    output logic                          o_done,
    output bsrt_pkg::t_rsp                o_rsp,
    output logic [bsrt_pkg::COUNT_W-1:0]  o_bad_total
);

    localparam int AW   = $clog2(SEG_COUNT);
    localparam int CW   = $clog2(SEG_COUNT + 1);
    localparam int BPW  = AW + 1;
    localparam int ADW  = bsrt_pkg::ADDR_W;
    localparam int PB   = bsrt_pkg::PAGE_BITS;
    localparam int LW   = bsrt_pkg::LSEG_W;

    typedef enum logic [8:0] {
        S_CLEAR      = 9'b000000001,
        S_IDLE       = 9'b000000010,
        S_RPT_EV     = 9'b000000100,
        S_LOOK_EV    = 9'b000001000,
        S_B_SCAN     = 9'b000010000,
        S_B_FRONT_EV = 9'b000100000,
        S_B_BACK_RD  = 9'b001000000,
        S_B_BACK_EV  = 9'b010000000,
        S_DONE       = 9'b100000000
    } t_state;

    t_state                        r_state, n_state;
    logic [AW-1:0]                 r_clr_addr, n_clr_addr;
    bsrt_pkg::t_req                r_req, n_req;
    logic [AW-1:0]                 r_seg_idx, n_seg_idx;
    logic [CW-1:0]                 r_i, n_i;
    logic [CW-1:0]                 r_limit, n_limit;
    logic [BPW-1:0]                r_bp, n_bp;
    logic [ADW-1:0]                r_result, n_result;
    logic                          r_status, n_status;
    logic [bsrt_pkg::COUNT_W-1:0]  r_bad_count, n_bad_count;

    logic [31:0]     w_rep32;
    logic [31:0]     w_look32;
    logic            w_rep_in_range;
    logic            w_look_in_range;
    logic [AW-1:0]   w_start_idx;
    logic [LW:0]     w_lim_raw;
    logic [31:0]     w_lim32;
    logic [CW-1:0]   w_limit;
    logic            w_i_gt_bp;
    logic [ADW-1:0]  w_base;

    logic            w_flag_we;
    logic [AW-1:0]   w_flag_wa;
    logic            w_flag_wd;
    logic [AW-1:0]   w_rd_addr;
    logic            w_flag_rd;
    logic            w_repl_we;
    logic [AW-1:0]   w_repl_rd;

    assign w_rep32         = 32'(i_req.seg_index);
    assign w_look32        = 32'(i_req.work_addr[ADW-1:PB]);
    assign w_rep_in_range  = w_rep32 < 32'(SEG_COUNT);
    assign w_look_in_range = w_look32 < 32'(SEG_COUNT);
    assign w_start_idx     = (i_req.action == bsrt_pkg::ACT_REPORT) ?
                             w_rep32[AW-1:0] : w_look32[AW-1:0];

    // scan limit: one or two times the logical count, clamped to the array
    assign w_lim_raw = i_single_level_scan ? {1'b0, i_logical_segments} :
                                             {i_logical_segments, 1'b0};
    assign w_lim32   = 32'(w_lim_raw);
    assign w_limit   = (w_lim32 > 32'(SEG_COUNT)) ? CW'(SEG_COUNT) : CW'(w_lim32);

    assign w_i_gt_bp = r_bp[BPW-1] || (32'(r_i) > 32'(r_bp[AW-1:0]));
    assign w_base    = 32'(w_repl_rd) << PB;

    always_comb begin
        case (r_state)
            S_IDLE:      w_rd_addr = w_start_idx;
            S_B_SCAN:    w_rd_addr = r_i[AW-1:0];
            S_B_BACK_RD: w_rd_addr = r_bp[AW-1:0];
            default:     w_rd_addr = r_seg_idx;
        endcase
    end

    assign w_flag_we = (r_state == S_CLEAR) ||
                       ((r_state == S_RPT_EV) && !w_flag_rd && r_req.is_bad);
    assign w_flag_wa = (r_state == S_CLEAR) ? r_clr_addr : r_seg_idx;
    assign w_flag_wd = (r_state != S_CLEAR);
    assign w_repl_we = (r_state == S_B_BACK_EV) && !w_flag_rd;

    bsrt_ram #(
        .WIDTH (1),
        .DEPTH (SEG_COUNT)
    ) u_flag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_flag_we),
        .i_wr_addr (w_flag_wa),
        .i_wr_data (w_flag_wd),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_flag_rd)
    );

    bsrt_ram #(
        .WIDTH (AW),
        .DEPTH (SEG_COUNT)
    ) u_repl_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_repl_we),
        .i_wr_addr (r_i[AW-1:0]),
        .i_wr_data (r_bp[AW-1:0]),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_repl_rd)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_req       = r_req;
        n_seg_idx   = r_seg_idx;
        n_i         = r_i;
        n_limit     = r_limit;
        n_bp        = r_bp;
        n_result    = r_result;
        n_status    = r_status;
        n_bad_count = r_bad_count;
        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(SEG_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_req     = i_req;
                    n_seg_idx = w_start_idx;
                    n_result  = '0;
                    n_status  = 1'b0;
                    n_state   = S_DONE;
                    case (i_req.action)
                        bsrt_pkg::ACT_REPORT: begin
                            if (w_rep_in_range) begin
                                n_state = S_RPT_EV;
                            end
                        end
                        bsrt_pkg::ACT_BUILD: begin
                            n_i     = '0;
                            n_limit = w_limit;
                            n_bp    = BPW'(SEG_COUNT - 1);
                            n_state = S_B_SCAN;
                        end
                        bsrt_pkg::ACT_TRANSLATE,
                        bsrt_pkg::ACT_SEG_QUERY,
                        bsrt_pkg::ACT_PAIR_QUERY: begin
                            n_result = i_req.work_addr;
                            if (w_look_in_range) begin
                                n_state = S_LOOK_EV;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RPT_EV: begin
                if (!w_flag_rd && r_req.is_bad && r_bad_count != bsrt_pkg::COUNT_MAX) begin
                    n_bad_count = r_bad_count + 1'b1;
                end
                n_state = S_DONE;
            end
            S_LOOK_EV: begin
                if (w_flag_rd) begin
                    n_result = r_req.keep_offset ?
                               (w_base | (r_req.work_addr & bsrt_pkg::PAGE_MASK)) : w_base;
                end
                n_state = S_DONE;
            end
            S_B_SCAN: begin
                if (r_i >= r_limit) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_B_FRONT_EV;
                end
            end
            S_B_FRONT_EV: begin
                if (!w_flag_rd) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_B_SCAN;
                end else if (w_i_gt_bp) begin
                    n_status = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_B_BACK_RD;
                end
            end
            S_B_BACK_RD: begin
                // back pointer ran past segment zero: no spare left
                if (r_bp[BPW-1]) begin
                    n_status = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_B_BACK_EV;
                end
            end
            S_B_BACK_EV: begin
                n_bp = r_bp - 1'b1;
                if (w_flag_rd) begin
                    n_state = S_B_BACK_RD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_B_SCAN;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_bad_count <= '0;
            r_bp        <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_bad_count <= n_bad_count;
            r_bp        <= n_bp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_seg_idx <= n_seg_idx;
        r_i       <= n_i;
        r_limit   <= n_limit;
        r_result  <= n_result;
        r_status  <= n_status;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_done      = (r_state == S_DONE);
    assign o_rsp       = '{result: r_result, status: r_status};
    assign o_bad_total = r_bad_count;

endmodule

[rtl/bad_segment_remap_table_top.sv]
// channel    dir  handshake                 payload
// s_axis     in   tvalid / tready           tdata: segment_index, is_bad, page_address
//                                           tuser: action
// m_axis     out  tvalid / tready           tdata: result_address, status, bad_total
// cfg        in   i_cfg_wr_en (no wait)     i_cfg_index, i_cfg_data
//
// report, translate and queries go from idle through an evaluation state that reads the
// flag memory to the done state, which loads the output register and returns to idle for
// the next request; a segment beyond the array or an unused action skips evaluation
// build visits a scan state and a front evaluation per front segment, plus a back read
// and a back evaluation per back segment probed, one read of the flag memory per step
// after reset every entry of the flag memory is cleared with tready low
// a finished result waits in the output register; one more request is taken and
// completed meanwhile and holds until the register frees
module bad_segment_remap_table_top #(
    parameter int SEG_COUNT = bsrt_pkg::SEG_COUNT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [8:0] segment_index, [9] is_bad, [41:10] page_address
    input  logic [bsrt_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [2:0] action
    input  logic [bsrt_pkg::ACTION_W-1:0]      s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] result_address, [32] status, [42:33] bad_total
    output logic [bsrt_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  logic                               i_cfg_wr_en,
    input  logic [bsrt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bsrt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int ADW = bsrt_pkg::ADDR_W;
    localparam int CTW = bsrt_pkg::COUNT_W;
    localparam int PAD = bsrt_pkg::M_TDATA_W - ADW - 1 - CTW;

    logic [bsrt_pkg::LSEG_W-1:0]  r_logical_segments;
    logic                         r_single_level_scan;
    logic                         r_slc_fold_enable;
    logic                         r_m_valid;
    logic [bsrt_pkg::M_TDATA_W-1:0] r_m_data;

    bsrt_pkg::t_action            w_action;
    logic [ADW-1:0]               w_work_addr;
    logic                         w_keep_offset;
    bsrt_pkg::t_req               w_req;
    logic                         w_accept;
    logic                         w_idle;
    logic                         w_done;
    logic                         w_out_free;
    bsrt_pkg::t_rsp               w_rsp;
    logic [CTW-1:0]               w_bad_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_logical_segments  <= bsrt_pkg::LSEG_RESET;
            r_single_level_scan <= 1'b0;
            r_slc_fold_enable   <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (bsrt_pkg::t_cfg_reg'(i_cfg_index))
                bsrt_pkg::CFG_LOGICAL_SEGMENTS:  r_logical_segments  <= i_cfg_data;
                bsrt_pkg::CFG_SINGLE_LEVEL_SCAN: r_single_level_scan <= i_cfg_data[0];
                bsrt_pkg::CFG_SLC_FOLD_ENABLE:   r_slc_fold_enable   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_action = bsrt_pkg::t_action'(s_axis_tuser);

    bsrt_addr u_addr (
        .i_action           (w_action),
        .i_page_address     (s_axis_tdata[41:10]),
        .i_logical_segments (r_logical_segments),
        .i_slc_fold_enable  (r_slc_fold_enable),
        .o_work_addr        (w_work_addr),
        .o_keep_offset      (w_keep_offset)
    );

    assign w_req = '{
        action:      w_action,
        seg_index:   s_axis_tdata[8:0],
        is_bad:      s_axis_tdata[9],
        work_addr:   w_work_addr,
        keep_offset: w_keep_offset
    };

    assign s_axis_tready = w_idle;
    assign w_accept      = s_axis_tvalid && w_idle;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    bsrt_seq #(
        .SEG_COUNT (SEG_COUNT)
    ) u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (w_accept),
        .i_req               (w_req),
        .i_logical_segments  (r_logical_segments),
        .i_single_level_scan (r_single_level_scan),
        .i_out_free          (w_out_free),
        .o_idle              (w_idle),
        .o_done              (w_done),
        .o_rsp               (w_rsp),
        .o_bad_total         (w_bad_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_done && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_out_free) begin
            r_m_data <= {{PAD{1'b0}}, w_bad_total, w_rsp.status, w_rsp.result};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

[rtl/bsrt_chk.sv]
`include "bad_segment_remap_table_top_assert.svh"

module bsrt_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [bsrt_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    input logic [bsrt_pkg::ACTION_W-1:0]      s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [bsrt_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input logic                               i_cfg_wr_en,
    input logic [bsrt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input logic [bsrt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // a stalled result holds
    `BSRT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed or dropped while stalled")

    // an error status only comes from a build, which returns a zero address
    `BSRT_ASSERT_SAME(a_status_zero_addr, m_axis_tvalid && m_axis_tdata[32], m_axis_tdata[31:0] == 32'd0, "error status with nonzero address")

    // requests are never taken back to back
    `BSRT_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken in back to back cycles")

    // clearing pass follows reset, nothing is taken or shown
    `BSRT_ASSERT_SAME(a_reset_quiet, $rose(i_rst_n), !s_axis_tready && !m_axis_tvalid, "block active right after reset")

endmodule

bind bad_segment_remap_table_top bsrt_chk u_chk (.*);
